@@ rtl/core/vend_pkg.sv @@
package vend_pkg;

  localparam int AISLES = 8;
  localparam int AISLE_W = (AISLES > 1) ? $clog2(AISLES) : 1;

  localparam int OP_W = 2;
  localparam int COIN_W = 8;
  localparam int NUM_W = 4;
  localparam int ID_W = 8;
  localparam int MONEY_W = 16;
  localparam int COUNT_W = 8;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_COIN   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_STOCK  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_COIN      = 3'd0,
    ST_NOCREDIT  = 3'd1,
    ST_NOSTOCK   = 3'd2,
    ST_SHORT     = 3'd3,
    ST_DISPENSED = 3'd4,
    ST_STOCKED   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic has_result;
  } dp_status_t;

endpackage

@@ rtl/core/vend_if.sv @@
interface vend_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  coin_value;
  logic [3:0]  aisle_number;
  logic [7:0]  product_id;
  logic [15:0] product_price;
  logic [7:0]  stock_amount;

  modport source (output valid, op, coin_value, aisle_number, product_id,
                  product_price, stock_amount, input ready);
  modport sink (input valid, op, coin_value, aisle_number, product_id,
                product_price, stock_amount, output ready);
endinterface

interface vend_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] credit_now;
  logic [15:0] money_out;
  logic [3:0]  aisle_used;

  modport source (output valid, status, credit_now, money_out, aisle_used,
                  input ready);
  modport sink (input valid, status, credit_now, money_out, aisle_used,
                output ready);
endinterface

@@ rtl/core/vend_ctrl.sv @@
module vend_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  input  vend_pkg::dp_status_t   dp_status,
  output vend_pkg::ctrl_cmd_t    cmd
);
  import vend_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   out_full;

  assign item_ready   = (state == S_IDLE);
  assign result_valid = out_full;

  always_comb begin
    cmd.capture = (state == S_IDLE) && item_valid;
    // The event runs once the output register is empty or is being drained.
    cmd.execute = (state == S_EXEC) && (!out_full || result_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          if (cmd.execute) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.execute && dp_status.has_result) begin
        out_full <= 1'b1;
      end else if (result_ready) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/vend_dp.sv @@
module vend_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  vend_pkg::ctrl_cmd_t                  cmd,
  output vend_pkg::dp_status_t                 dp_status,
  input  logic [vend_pkg::OP_W-1:0]            op,
  input  logic [vend_pkg::COIN_W-1:0]          coin_value,
  input  logic [vend_pkg::NUM_W-1:0]           aisle_number,
  input  logic [vend_pkg::ID_W-1:0]            product_id,
  input  logic [vend_pkg::MONEY_W-1:0]         product_price,
  input  logic [vend_pkg::COUNT_W-1:0]         stock_amount,
  output logic [vend_pkg::STATUS_W-1:0]        status,
  output logic [vend_pkg::MONEY_W-1:0]         credit_now,
  output logic [vend_pkg::MONEY_W-1:0]         money_out,
  output logic [vend_pkg::NUM_W-1:0]           aisle_used
);
  import vend_pkg::*;

  // Captured event.
  op_t                q_op;
  logic [COIN_W-1:0]  q_coin;
  logic [NUM_W-1:0]   q_num;
  logic [ID_W-1:0]    q_id;
  logic [MONEY_W-1:0] q_price;
  logic [COUNT_W-1:0] q_amount;

  // Machine state.
  logic               has_credit;
  logic [MONEY_W-1:0] credit;
  logic [AISLES-1:0]  aisle_busy;
  logic [ID_W-1:0]    aisle_product [AISLES];
  logic [MONEY_W-1:0] aisle_price [AISLES];
  logic [COUNT_W-1:0] aisle_stock [AISLES];

  // Event evaluation.
  logic [MONEY_W:0]   coin_sum;
  logic [MONEY_W-1:0] credit_next;
  logic               num_ok;
  logic [AISLE_W-1:0] sel_idx;
  logic               sel_busy;
  logic [MONEY_W-1:0] sel_price;
  logic [COUNT_W-1:0] sel_stock;
  logic [AISLES-1:0]  match;
  logic               match_hit;
  logic [AISLE_W-1:0] match_idx;
  logic               free_hit;
  logic [AISLE_W-1:0] free_idx;
  logic [COUNT_W:0]   stock_sum;
  logic [COUNT_W-1:0] restock_count;

  status_t            res_status;
  logic [MONEY_W-1:0] res_credit;
  logic [MONEY_W-1:0] res_money;
  logic [NUM_W-1:0]   res_aisle;
  logic               do_dispense;

  assign dp_status.has_result = (q_op != OP_NONE);

  always_comb begin
    coin_sum = {1'b0, credit} + {{(MONEY_W + 1 - COIN_W){1'b0}}, q_coin};
    if (!has_credit) begin
      credit_next = {{(MONEY_W - COIN_W){1'b0}}, q_coin};
    end else if (coin_sum[MONEY_W]) begin
      credit_next = {MONEY_W{1'b1}};
    end else begin
      credit_next = coin_sum[MONEY_W-1:0];
    end
  end

  always_comb begin
    num_ok    = (q_num != '0) && (q_num <= NUM_W'(AISLES));
    sel_idx   = AISLE_W'(q_num - NUM_W'(1));
    sel_busy  = aisle_busy[sel_idx];
    sel_price = aisle_price[sel_idx];
    sel_stock = aisle_stock[sel_idx];
  end

  // Lowest matching aisle and lowest free aisle, searched in parallel.
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = AISLES - 1; i >= 0; i--) begin
      match[i] = aisle_busy[i] && (aisle_product[i] == q_id);
      if (match[i]) begin
        match_hit = 1'b1;
        match_idx = AISLE_W'(i);
      end
      if (!aisle_busy[i]) begin
        free_hit = 1'b1;
        free_idx = AISLE_W'(i);
      end
    end
  end

  always_comb begin
    stock_sum = {1'b0, aisle_stock[match_idx]} + {1'b0, q_amount};
    restock_count = stock_sum[COUNT_W] ? {COUNT_W{1'b1}} : stock_sum[COUNT_W-1:0];
  end

  always_comb begin
    res_status  = ST_COIN;
    res_credit  = credit;
    res_money   = '0;
    res_aisle   = '0;
    do_dispense = 1'b0;
    unique case (q_op)
      OP_COIN: begin
        res_credit = credit_next;
      end
      OP_BUTTON: begin
        if (!has_credit) begin
          res_status = ST_NOCREDIT;
        end else if (!num_ok || !sel_busy || sel_stock == '0) begin
          res_status = ST_NOSTOCK;
        end else if (sel_price > credit) begin
          res_status = ST_SHORT;
          res_money  = sel_price - credit;
        end else begin
          res_status  = ST_DISPENSED;
          res_money   = credit - sel_price;
          res_credit  = '0;
          res_aisle   = q_num;
          do_dispense = 1'b1;
        end
      end
      OP_STOCK: begin
        if (match_hit) begin
          res_status = ST_STOCKED;
          res_aisle  = NUM_W'(match_idx) + NUM_W'(1);
        end else if (free_hit) begin
          res_status = ST_STOCKED;
          res_aisle  = NUM_W'(free_idx) + NUM_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      OP_NONE: begin
        res_status = ST_COIN;
      end
      default: res_status = ST_COIN;
    endcase
  end

  // Input capture and result word; payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_op     <= op_t'(op);
      q_coin   <= coin_value;
      q_num    <= aisle_number;
      q_id     <= product_id;
      q_price  <= product_price;
      q_amount <= stock_amount;
    end
    if (cmd.execute && dp_status.has_result) begin
      status     <= res_status;
      credit_now <= res_credit;
      money_out  <= res_money;
      aisle_used <= res_aisle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      has_credit <= 1'b0;
      credit     <= '0;
      aisle_busy <= '0;
      for (int i = 0; i < AISLES; i++) aisle_stock[i] <= '0;
    end else if (cmd.execute) begin
      if (q_op == OP_COIN) begin
        has_credit <= 1'b1;
        credit     <= credit_next;
      end
      if (do_dispense) begin
        has_credit           <= 1'b0;
        credit               <= '0;
        aisle_stock[sel_idx] <= sel_stock - COUNT_W'(1);
        if (sel_stock == COUNT_W'(1)) aisle_busy[sel_idx] <= 1'b0;
      end
      if (q_op == OP_STOCK) begin
        if (match_hit) begin
          aisle_stock[match_idx] <= restock_count;
        end else if (free_hit) begin
          aisle_busy[free_idx]  <= 1'b1;
          aisle_stock[free_idx] <= q_amount;
        end
      end
    end
  end

  // Product and price entries are defined only once an aisle is claimed.
  always_ff @(posedge clk) begin
    if (cmd.execute && q_op == OP_STOCK && !match_hit && free_hit) begin
      aisle_product[free_idx] <= q_id;
      aisle_price[free_idx]   <= q_price;
    end
  end

endmodule

@@ rtl/core/vending_controller.sv @@
// Vending machine controller.
// The item channel takes one event word: op selects a coin (coin_value),
// an aisle button press (aisle_number, 1-based) or a stocking request
// (product_id, product_price, stock_amount). Op 3 is ignored and gives no result.
// The result channel returns one word per event: status, the credit after
// the event, the change or shortfall, and the aisle used.
// An event is taken into the capture register and then evaluated, where the
// aisle table is searched in parallel and updated; the result word is then
// registered in the output register. The block takes no new event until the
// last one is evaluated (the controller's capture and evaluate steps).
// The result sits in an output register. While the receiver stalls, a new
// event is still accepted and waits in the capture register until the
// output register drains.
// Reset clears the credit, the mode and every aisle's busy flag and count;
// product ids and prices are written when an aisle is claimed.
module vending_controller (
  input logic         clk,
  input logic         rst,
  vend_item_if.sink   item,
  vend_result_if.source result
);
  import vend_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  vend_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .dp_status    (dp_status),
    .cmd          (cmd)
  );

  vend_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .dp_status     (dp_status),
    .op            (item.op),
    .coin_value    (item.coin_value),
    .aisle_number  (item.aisle_number),
    .product_id    (item.product_id),
    .product_price (item.product_price),
    .stock_amount  (item.stock_amount),
    .status        (result.status),
    .credit_now    (result.credit_now),
    .money_out     (result.money_out),
    .aisle_used    (result.aisle_used)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import vend_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_EVENTS = 210;
  localparam int STORM_COINS = 265;

  typedef struct {
    op_t         op;
    logic [7:0]  coin;
    logic [3:0]  aisle;
    logic [7:0]  id;
    logic [15:0] price;
    logic [7:0]  amount;
  } vend_event_t;

  typedef struct {
    status_t     status;
    logic [15:0] credit_now;
    logic [15:0] money_out;
    logic [3:0]  aisle_used;
  } receipt_t;

  typedef struct {
    vend_event_t ev;
    bit          typed;
    receipt_t    want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  vend_item_if   item_ch ();
  vend_result_if res_ch ();

  vending_controller u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the machine.
  bit         sh_has_credit;
  int         sh_credit;
  bit         sh_busy    [AISLES];
  logic [7:0] sh_product [AISLES];
  int         sh_price   [AISLES];
  int         sh_stock   [AISLES];

  receipt_t    receipts_due[$];
  script_row_t script[$];
  receipt_t    any_receipt = '{ST_COIN, 16'd0, 16'd0, 4'd0};

  int src_idle_pct;
  int rcv_idle_pct;
  int n_events;
  int n_checked;
  int n_dispensed;
  int n_full;
  int n_saturated;
  int errors;
  int quiet;

  // Applies one event to the shadow machine; returns 0 when no receipt is due.
  function automatic bit vend_apply(input vend_event_t ev, output receipt_t rc);
    int slot;
    int total;
    rc.status = ST_COIN;
    rc.money_out = '0;
    rc.aisle_used = '0;
    slot = int'(ev.aisle) - 1;
    case (ev.op)
      OP_COIN: begin
        if (!sh_has_credit) begin
          sh_credit = int'(ev.coin);
          sh_has_credit = 1'b1;
        end else begin
          total = sh_credit + int'(ev.coin);
          sh_credit = (total > 65535) ? 65535 : total;
        end
      end
      OP_BUTTON: begin
        if (!sh_has_credit) begin
          rc.status = ST_NOCREDIT;
        end else if (ev.aisle == 0 || int'(ev.aisle) > AISLES) begin
          rc.status = ST_NOSTOCK;
        end else if (!sh_busy[slot] || sh_stock[slot] == 0) begin
          rc.status = ST_NOSTOCK;
        end else if (sh_price[slot] > sh_credit) begin
          rc.status = ST_SHORT;
          rc.money_out = 16'(sh_price[slot] - sh_credit);
        end else begin
          rc.status = ST_DISPENSED;
          rc.money_out = 16'(sh_credit - sh_price[slot]);
          rc.aisle_used = ev.aisle;
          sh_stock[slot]--;
          if (sh_stock[slot] == 0) sh_busy[slot] = 1'b0;
          sh_credit = 0;
          sh_has_credit = 1'b0;
        end
      end
      OP_STOCK: begin
        slot = -1;
        for (int i = 0; i < AISLES; i++)
          if (slot < 0 && sh_busy[i] && sh_product[i] == ev.id) slot = i;
        if (slot >= 0) begin
          total = sh_stock[slot] + int'(ev.amount);
          sh_stock[slot] = (total > 255) ? 255 : total;
        end else begin
          for (int i = 0; i < AISLES; i++)
            if (slot < 0 && !sh_busy[i]) slot = i;
          if (slot >= 0) begin
            sh_busy[slot] = 1'b1;
            sh_product[slot] = ev.id;
            sh_price[slot] = int'(ev.price);
            sh_stock[slot] = int'(ev.amount);
          end
        end
        if (slot >= 0) begin
          rc.status = ST_STOCKED;
          rc.aisle_used = 4'(slot + 1);
        end else begin
          rc.status = ST_FULL;
        end
      end
      default: return 1'b0;
    endcase
    rc.credit_now = 16'(sh_credit);
    return 1'b1;
  endfunction

  function automatic vend_event_t mk_event(op_t op, int coin, int aisle, int id, int price,
                                           int amount);
    vend_event_t ev;
    ev.op = op;
    ev.coin = 8'(coin);
    ev.aisle = 4'(aisle);
    ev.id = 8'(id);
    ev.price = 16'(price);
    ev.amount = 8'(amount);
    return ev;
  endfunction

  function automatic vend_event_t rand_event(op_t op);
    return mk_event(op, $urandom_range(255), $urandom_range(15), $urandom_range(255),
                    $urandom_range(65535), $urandom_range(255));
  endfunction

  function automatic receipt_t mk_receipt(status_t st, int credit, int money, int aisle);
    receipt_t rc;
    rc.status = st;
    rc.credit_now = 16'(credit);
    rc.money_out = 16'(money);
    rc.aisle_used = 4'(aisle);
    return rc;
  endfunction

  function automatic void script_add(vend_event_t ev);
    script.push_back('{ev, 1'b0, any_receipt});
  endfunction

  function automatic void script_add_want(vend_event_t ev, receipt_t want);
    script.push_back('{ev, 1'b1, want});
  endfunction

  // Drives one word and waits for it to be taken. Returns at a falling edge
  // with valid still high, so back-to-back words drop valid only for idle gaps.
  task automatic send_word(input vend_event_t ev, input bit typed, input receipt_t want);
    receipt_t rc;
    while ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.op            <= ev.op;
    item_ch.coin_value    <= ev.coin;
    item_ch.aisle_number  <= ev.aisle;
    item_ch.product_id    <= ev.id;
    item_ch.product_price <= ev.price;
    item_ch.stock_amount  <= ev.amount;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    if (vend_apply(ev, rc)) begin
      receipts_due.push_back(typed ? want : rc);
      n_events++;
    end
    @(negedge clk);
  endtask

  task automatic random_burst();
    int          kind;
    int          roll;
    int          busy_list[$];
    vend_event_t ev;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // A purchase: a few coins, then a button, mostly on a stocked aisle.
      repeat ($urandom_range(1, 4)) send_word(rand_event(OP_COIN), 1'b0, any_receipt);
      ev = rand_event(OP_BUTTON);
      for (int i = 0; i < AISLES; i++)
        if (sh_busy[i] && sh_stock[i] > 0) busy_list.push_back(i + 1);
      if (busy_list.size() > 0 && $urandom_range(99) < 80)
        ev.aisle = 4'(busy_list[$urandom_range(busy_list.size() - 1)]);
      send_word(ev, 1'b0, any_receipt);
    end else if (kind < 60) begin
      ev = rand_event(OP_STOCK);
      if ($urandom_range(99) < 75) ev.id = 8'($urandom_range(11));
      if ($urandom_range(99) < 70) ev.price = 16'($urandom_range(700));
      roll = $urandom_range(99);
      if (roll < 60) ev.amount = 8'($urandom_range(4));
      else if (roll >= 90) ev.amount = 8'hff;
      send_word(ev, 1'b0, any_receipt);
    end else if (kind < 75) begin
      send_word(rand_event(OP_BUTTON), 1'b0, any_receipt);
    end else if (kind < 90) begin
      send_word(rand_event(OP_COIN), 1'b0, any_receipt);
    end else begin
      send_word(rand_event(OP_NONE), 1'b0, any_receipt);
    end
  endtask

  always @(negedge clk) res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin
    receipt_t exp_rc;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (receipts_due.size() == 0) begin
        $error("result word with no event pending: status %0d", res_ch.status);
        errors++;
      end else begin
        exp_rc = receipts_due.pop_front();
        n_checked++;
        if (res_ch.status == ST_DISPENSED) n_dispensed++;
        if (res_ch.status == ST_FULL) n_full++;
        if (res_ch.credit_now == 16'hffff) n_saturated++;
        if (res_ch.status !== exp_rc.status) begin
          $error("status: expected %0d, got %0d", exp_rc.status, res_ch.status);
          errors++;
        end
        if (res_ch.credit_now !== exp_rc.credit_now) begin
          $error("credit_now: expected %0d, got %0d", exp_rc.credit_now, res_ch.credit_now);
          errors++;
        end
        if (res_ch.money_out !== exp_rc.money_out) begin
          $error("money_out: expected %0d, got %0d", exp_rc.money_out, res_ch.money_out);
          errors++;
        end
        if (res_ch.aisle_used !== exp_rc.aisle_used) begin
          $error("aisle_used: expected %0d, got %0d", exp_rc.aisle_used, res_ch.aisle_used);
          errors++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int best;
    int best_price;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = OP_NONE;
    item_ch.coin_value = '0;
    item_ch.aisle_number = '0;
    item_ch.product_id = '0;
    item_ch.product_price = '0;
    item_ch.stock_amount = '0;
    res_ch.ready = 1'b0;
    src_idle_pct = 0;
    rcv_idle_pct = 0;

    // Directed words. Rows with a typed receipt follow from the rules at a glance.
    script_add_want(mk_event(OP_BUTTON, 0, 3, 0, 0, 0), mk_receipt(ST_NOCREDIT, 0, 0, 0));
    script_add(mk_event(OP_NONE, 8'haa, 15, 8'hff, 16'hffff, 8'hff));
    script_add_want(mk_event(OP_COIN, 0, 0, 0, 0, 0), mk_receipt(ST_COIN, 0, 0, 0));
    script_add_want(mk_event(OP_BUTTON, 0, 0, 0, 0, 0), mk_receipt(ST_NOSTOCK, 0, 0, 0));
    script_add_want(mk_event(OP_BUTTON, 0, 15, 0, 0, 0), mk_receipt(ST_NOSTOCK, 0, 0, 0));
    script_add_want(mk_event(OP_BUTTON, 0, AISLES + 1, 0, 0, 0),
                    mk_receipt(ST_NOSTOCK, 0, 0, 0));
    script_add_want(mk_event(OP_BUTTON, 0, 2, 0, 0, 0), mk_receipt(ST_NOSTOCK, 0, 0, 0));
    // A new product with zero units still claims an aisle.
    script_add_want(mk_event(OP_STOCK, 0, 0, 0, 65535, 0), mk_receipt(ST_STOCKED, 0, 0, 1));
    script_add_want(mk_event(OP_BUTTON, 0, 1, 0, 0, 0), mk_receipt(ST_NOSTOCK, 0, 0, 0));
    // Restocking keeps the old price, and the count saturates.
    script_add_want(mk_event(OP_STOCK, 0, 0, 0, 7, 255), mk_receipt(ST_STOCKED, 0, 0, 1));
    script_add_want(mk_event(OP_STOCK, 0, 0, 0, 0, 1), mk_receipt(ST_STOCKED, 0, 0, 1));
    script_add_want(mk_event(OP_COIN, 255, 0, 0, 0, 0), mk_receipt(ST_COIN, 255, 0, 0));
    script_add_want(mk_event(OP_BUTTON, 0, 1, 0, 0, 0), mk_receipt(ST_SHORT, 255, 65280, 0));
    for (int k = 1; k < AISLES; k++) script_add(mk_event(OP_STOCK, 0, 0, k, 10 * k, k));
    script_add_want(mk_event(OP_STOCK, 0, 0, 200, 1, 1), mk_receipt(ST_FULL, 255, 0, 0));
    // The last unit of aisle 2 goes, so the next new product lands there.
    script_add(mk_event(OP_BUTTON, 0, 2, 0, 0, 0));
    script_add(mk_event(OP_STOCK, 0, 0, 200, 65535, 3));
    script_add(mk_event(OP_COIN, 128, 0, 0, 0, 0));
    script_add(mk_event(OP_BUTTON, 0, 2, 0, 0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 50 : 0;
      rcv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 23 : 0;
      if (phase == 0)
        foreach (script[i]) send_word(script[i].ev, script[i].typed, script[i].want);
      if (phase == 2) begin
        // Enough large coins to pin the credit at its ceiling, then buy the dearest item.
        repeat (STORM_COINS) begin
          send_word(mk_event(OP_COIN, $urandom_range(250, 255), 0, 0, 0, 0), 1'b0,
                    any_receipt);
        end
        best = 1;
        best_price = -1;
        for (int i = 0; i < AISLES; i++) begin
          if (sh_busy[i] && sh_stock[i] > 0 && sh_price[i] > best_price) begin
            best = i + 1;
            best_price = sh_price[i];
          end
        end
        send_word(mk_event(OP_BUTTON, 0, best, 0, 0, 0), 1'b0, any_receipt);
      end
      while (n_events < script.size() + (phase + 1) * PHASE_EVENTS) random_burst();
    end
    item_ch.valid <= 1'b0;

    while (receipts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d events sent, %0d result words checked", n_events, n_checked);
    $display("%0d sales, %0d rejected stockings, %0d results at full credit", n_dispensed,
             n_full, n_saturated);
    if (errors == 0 && receipts_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
